// ===== src/cat_pkg.sv =====
// ----------------------------------------------------------------------------
// cat_pkg
// Shared widths, angle table and pipeline payload type for the CORDIC
// vector-to-angle pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cat_pkg;

  // input field width
  localparam int unsigned InW = 14;
  // internal coordinate width, with headroom for CORDIC gain
  localparam int unsigned CoordW = 16;
  // angle accumulator width, full turn is 2^AccW
  localparam int unsigned AccW = 16;
  // output angle width
  localparam int unsigned AngleW = 8;
  // number of table entries
  localparam int unsigned TableSize = 8;
  // half a turn in accumulator units
  localparam logic [AccW-1:0] HalfTurn = 16'h8000;

  // payload carried from stage to stage
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [AccW-1:0]          acc;
  } vec_t;

  // arctan(2^-i) in accumulator units
  function automatic logic [AccW-1:0] atan_step(input logic [2:0] idx);
    logic [AccW-1:0] val;
    unique case (idx)
      3'd0: val = 16'd8192;
      3'd1: val = 16'd4836;
      3'd2: val = 16'd2555;
      3'd3: val = 16'd1297;
      3'd4: val = 16'd651;
      3'd5: val = 16'd325;
      3'd6: val = 16'd162;
      3'd7: val = 16'd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== src/cat_stage.sv =====
// ----------------------------------------------------------------------------
// cat_stage
// One registered CORDIC vectoring iteration: shifts both coordinates by the
// iteration index, rotates toward y equal to zero and updates the angle.
// ----------------------------------------------------------------------------
`default_nettype none

module cat_stage
  import cat_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire vec_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output vec_t      out_data_o
);

  localparam logic [2:0] IdxBits = 3'(IDX);

  logic signed [CoordW-1:0] sx, sy;
  logic [AccW-1:0]          step;
  vec_t                     data_d, data_q;
  logic                     valid_q;
  logic                     load;

  // arithmetic shifts and table angle for this iteration
  assign sx   = in_data_i.x >>> IDX;
  assign sy   = in_data_i.y >>> IDX;
  assign step = atan_step(IdxBits);

  // rotate toward the x axis, no change when y is zero
  always_comb begin
    data_d = in_data_i;
    if (in_data_i.y > 0) begin
      data_d.x   = in_data_i.x + sy;
      data_d.y   = in_data_i.y - sx;
      data_d.acc = in_data_i.acc + step;
    end else if (in_data_i.y < 0) begin
      data_d.x   = in_data_i.x - sy;
      data_d.y   = in_data_i.y + sx;
      data_d.acc = in_data_i.acc - step;
    end
  end

  // stage holds only while full and the next stage stalls
  assign in_stall_o = valid_q && out_stall_i;
  assign load       = !in_stall_o;

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ===== src/cordic_atan2_byte_angle.sv =====
// ----------------------------------------------------------------------------
// cordic_atan2_byte_angle
// Direction of a signed vector as an 8-bit binary angle, computed by a
// fully pipelined CORDIC in vectoring mode.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: x_in_i / y_in_i with in_valid_i; an item is taken at a
//   clock edge where in_valid_i is high and in_stall_o is low.
//   Output channel: angle_o with out_valid_o; the item is delivered at an
//   edge where out_valid_o is high and out_stall_i is low.
//   angle_o counts 256 units per full turn, zero along positive x.
//   Pipeline: one quadrant-fold register plus one register per iteration,
//   the last being the output register.
//   Throughput: one item per cycle while out_stall_i is low; every stage has its own valid bit.
//   Stall: each stage holds only if it is full and its successor holds, so
//   bubbles are squeezed out and the pipeline keeps accepting items until
//   all stages are full behind a stalled output.
//   Reset: asynchronous, active low; all valid bits clear, the pipeline is
//   empty and ready after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cordic_atan2_byte_angle
  import cat_pkg::*;
#(
  parameter int unsigned ITERATIONS = 7
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic signed [InW-1:0]   x_in_i,
  input  wire logic signed [InW-1:0]   y_in_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic             [AngleW-1:0] angle_o
);

  localparam int unsigned NumIter = (ITERATIONS < TableSize) ? ITERATIONS : TableSize;

  logic valid [0:NumIter];
  logic stall [0:NumIter];
  vec_t data  [0:NumIter];

  logic                     s0_valid_q;
  vec_t                     s0_d, s0_q;
  logic signed [CoordW-1:0] x_ext, y_ext;
  logic                     s0_load;

  // fold left half-plane into the right one, start at half a turn
  assign x_ext = CoordW'(x_in_i);
  assign y_ext = CoordW'(y_in_i);

  always_comb begin
    if (x_in_i < 0) begin
      s0_d.x   = -x_ext;
      s0_d.y   = -y_ext;
      s0_d.acc = HalfTurn;
    end else begin
      s0_d.x   = x_ext;
      s0_d.y   = y_ext;
      s0_d.acc = '0;
    end
  end

  assign in_stall_o = s0_valid_q && stall[0];
  assign s0_load    = !in_stall_o;

  // first stage valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_load) begin
      s0_valid_q <= in_valid_i;
    end
  end

  // first stage payload
  always_ff @(posedge clk_i) begin
    if (s0_load && in_valid_i) begin
      s0_q <= s0_d;
    end
  end

  assign valid[0] = s0_valid_q;
  assign data[0]  = s0_q;

  // one registered stage per iteration
  for (genvar k = 1; k <= NumIter; k++) begin : g_iter
    cat_stage #(
      .IDX(k - 1)
    ) u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (valid[k-1]),
      .in_stall_o (stall[k-1]),
      .in_data_i  (data[k-1]),
      .out_valid_o(valid[k]),
      .out_stall_i(stall[k]),
      .out_data_o (data[k])
    );
  end

  // last stage is the output register
  assign stall[NumIter] = out_stall_i;
  assign out_valid_o    = valid[NumIter];
  assign angle_o        = data[NumIter].acc[AccW-1 -: AngleW];

  // no stage may hold while the output is being drained
  a_no_stall_when_drained: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !out_stall_i |-> !in_stall_o
  ) else $error("input stalled while output is not stalled");

  // right half-plane items start with a zero angle
  a_fold_right: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !x_in_i[InW-1]) |=> (s0_valid_q && s0_q.acc == '0)
  ) else $error("right half-plane item did not start at zero angle");

  // left half-plane items start at half a turn with x made nonnegative
  a_fold_left: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && x_in_i[InW-1])
      |=> (s0_valid_q && s0_q.acc == HalfTurn && !s0_q.x[CoordW-1])
  ) else $error("left half-plane item was not folded");

endmodule

`default_nettype wire

// ===== tb/cordic_atan2_byte_angle_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cordic_atan2_byte_angle_checker
// Watches both channels of the vector-to-angle pipeline. It computes the
// expected angle of every accepted vector and compares it against the
// delivered angles in order.
// ----------------------------------------------------------------------------

module cordic_atan2_byte_angle_checker
  import cat_pkg::*;
#(
  parameter int unsigned ITERATIONS = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic signed [InW-1:0]   x_in_i,
  input  logic signed [InW-1:0]   y_in_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic        [AngleW-1:0] angle_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  // arctan(2^-i) in 1/65536 of a turn, entry 0 last
  localparam logic [TableSize-1:0][AccW-1:0] StepAngle = {
    16'd81, 16'd162, 16'd325, 16'd651, 16'd1297, 16'd2555, 16'd4836, 16'd8192
  };

  logic [AngleW-1:0] angle_queue [$];

  // vectoring-mode rotation toward the positive x axis
  function automatic logic [AngleW-1:0] predict_angle(input logic signed [InW-1:0] xv,
                                                      input logic signed [InW-1:0] yv);
    int              x;
    int              y;
    int              sx;
    int              sy;
    logic [AccW-1:0] acc;
    x   = xv;
    y   = yv;
    acc = '0;
    // left half plane: fold over and start from half a turn
    if (x < 0) begin
      x   = -x;
      y   = -y;
      acc = HalfTurn;
    end
    for (int i = 0; i < ITERATIONS && i < TableSize; i++) begin
      sx = x >>> i;
      sy = y >>> i;
      if (y > 0) begin
        x   = x + sy;
        y   = y - sx;
        acc = acc + StepAngle[i];
      end else if (y < 0) begin
        x   = x - sy;
        y   = y + sx;
        acc = acc - StepAngle[i];
      end
    end
    return acc[AccW-1 -: AngleW];
  endfunction

  // track accepted vectors and delivered angles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_queue.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (angle_queue.size() == 0) begin
          $display("%0t: unexpected angle item, expected none, actual %0d",
                   $time, angle_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          if (angle_i !== angle_queue[0]) begin
            $display("%0t: angle expected %0d, actual %0d",
                     $time, angle_queue[0], angle_i);
            fail_count_o <= fail_count_o + 1;
          end
          void'(angle_queue.pop_front());
        end
      end
      if (in_valid_i && !in_stall_i) begin
        angle_queue.push_back(predict_angle(x_in_i, y_in_i));
      end
      pending_o <= angle_queue.size();
    end
  end

endmodule

// ===== tb/tb_cordic_atan2_byte_angle.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cordic_atan2_byte_angle
// Drives directed and random vectors into the CORDIC angle pipeline under
// several sender gap and receiver stall mixes, including one long output
// hold-off, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------

module tb_cordic_atan2_byte_angle;
  import cat_pkg::*;

  localparam int unsigned Iterations  = 7;
  localparam int          RandomItems = 175;
  localparam int          HoldCycles  = 40;
  localparam int          CycleLimit  = 200000;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic signed [InW-1:0]    x_in_i      = '0;
  logic signed [InW-1:0]    y_in_i      = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic        [AngleW-1:0] angle_o;

  int fail_count;
  int pending;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_req    = 0;
  int cycle_count = 0;

  cordic_atan2_byte_angle #(
    .ITERATIONS(Iterations)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .x_in_i     (x_in_i),
    .y_in_i     (y_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .angle_o    (angle_o)
  );

  cordic_atan2_byte_angle_checker #(
    .ITERATIONS(Iterations)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .x_in_i      (x_in_i),
    .y_in_i      (y_in_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .angle_i     (angle_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // 2 ns clock
  always #1 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("cordic_atan2_byte_angle: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // offer one vector, wait for it to be taken, then maybe leave a gap
  task automatic send_vec(input logic signed [InW-1:0] xv, input logic signed [InW-1:0] yv);
    in_valid_i <= 1'b1;
    x_in_i     <= xv;
    y_in_i     <= yv;
    do @(posedge clk_i); while (in_stall_o);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // random vector: mostly full range, some near the origin, on an axis,
  // or with the most negative x
  task automatic send_random_vec();
    logic signed [InW-1:0] xv;
    logic signed [InW-1:0] yv;
    int                    kind;
    kind = $urandom_range(9);
    xv   = InW'($urandom_range(16383));
    yv   = InW'($urandom_range(16383));
    if (kind == 6 || kind == 7) begin
      xv = InW'(int'($urandom_range(31)) - 16);
      yv = InW'(int'($urandom_range(31)) - 16);
    end else if (kind == 8) begin
      if ($urandom_range(1)) xv = '0;
      else yv = '0;
    end else if (kind == 9) begin
      xv = -14'sd8192;
    end
    send_vec(xv, yv);
  endtask

  // stimulus and verdict
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero vector, axes, corners, tiny vectors, y going to zero
    send_vec(14'sd0, 14'sd0);
    send_vec(14'sd8191, 14'sd0);
    send_vec(-14'sd8192, 14'sd0);
    send_vec(14'sd0, 14'sd8191);
    send_vec(14'sd0, -14'sd8192);
    send_vec(14'sd8191, 14'sd8191);
    send_vec(14'sd8191, -14'sd8192);
    send_vec(-14'sd8192, 14'sd8191);
    send_vec(-14'sd8192, -14'sd8192);
    send_vec(-14'sd8192, 14'sd1);
    send_vec(14'sd1, 14'sd0);
    send_vec(-14'sd1, 14'sd0);
    send_vec(14'sd0, 14'sd1);
    send_vec(14'sd0, -14'sd1);
    send_vec(14'sd1, 14'sd1);
    send_vec(-14'sd1, -14'sd1);
    send_vec(-14'sd1, 14'sd1);
    send_vec(14'sd1, -14'sd1);
    send_vec(14'sd5, -14'sd3);
    send_vec(-14'sd7, 14'sd2);
    send_vec(14'sd4096, 14'sd4096);

    // long output hold-off while the sender keeps going
    hold_req = hold_req + 1;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      for (int n = 0; n < RandomItems; n++) begin
        send_random_vec();
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (Iterations + 4) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("cordic_atan2_byte_angle: match");
    end else begin
      $display("cordic_atan2_byte_angle: mismatch");
    end
    $finish;
  end

endmodule
